@@ hw/rtl/arpc_pkg.sv @@
// arp cache package: table size, field codes and the request, response and
// table entry word types used by the cache; the generic ram does not import it
`timescale 1ns / 1ps

package arpc_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   localparam logic [1:0] OP_ARP_FRAME = 2'd0;
   localparam logic [1:0] OP_LEARN     = 2'd1;
   localparam logic [1:0] OP_LOOKUP    = 2'd2;

   localparam logic [15:0] ARP_REQUEST = 16'd1;
   localparam logic [15:0] ARP_REPLY   = 16'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_ZERO_IP  = 2'd2;
   localparam logic [1:0] ST_BAD_CODE = 2'd3;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] arp_opcode;
      logic [47:0] sender_mac;
      logic [31:0] sender_ip;
      logic [31:0] target_ip;
      logic [1:0]  port;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        send_reply;
      logic [31:0] reply_ip;
      logic        hit;
      logic [47:0] result_mac;
      logic [1:0]  result_port;
   } rsp_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
      logic [1:0]  port;
   } entry_type;

endpackage

@@ hw/rtl/arpc_ram.sv @@
// generic simple dual port ram: one write port, one read port with
// registered read data; no dependencies
`timescale 1ns / 1ps

module arpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/arp_cache_with_reply.sv @@
// arp cache top level: command port, local ip register, table walk control
// depends on arpc_pkg and arpc_ram
`timescale 1ns / 1ps

// One event is taken when start is high and busy is low; busy stays high
// until the event is finished, and its single response word shows on rsp_word
// with rsp_strobe for one cycle, starting as busy falls. The receiver cannot
// stall, so it must take the word in that cycle. An ARP frame, an invalid
// zero ip or an unused operation goes straight to the finish state. Learn and
// lookup walk the table one entry per cycle through the ram read port,
// stopping at the first match or after the last entry on a miss. The free
// slot comes from per-entry valid bits, so inserts need no walk. local_ip
// must be written through csr_wr_en / csr_wr_data only while the block is
// idle; the block itself does not enforce this. Reset clears the table at once.

module arp_cache_with_reply (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  arpc_pkg::req_type req_word,
   output logic             rsp_strobe,
   output arpc_pkg::rsp_type rsp_word,
   input  logic             csr_wr_en,
   input  logic [31:0]      csr_wr_data
);
   import arpc_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   localparam int ENTRY_W = $bits(entry_type);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);

   state_type            state_ff;
   req_type              req_ff;
   logic [31:0]          key_ff;
   logic [31:0]          local_ip_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 pend_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic                 hit_ff;
   logic [47:0]          hit_mac_ff;
   logic [1:0]           hit_port_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic                 rsp_strobe_ff;
   rsp_type              rsp_word_ff;

   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [ENTRY_W-1:0]   rd_bits;
   entry_type            rd_entry;
   logic                 wr_en;
   entry_type            wr_entry;
   logic                 match;
   logic                 free_found;
   logic [IDX_W-1:0]     free_idx;
   logic                 arp_store;
   logic                 do_insert;
   logic                 need_scan;
   rsp_type              rsp_in;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign need_scan = (req_word.operation == OP_LEARN && req_word.sender_ip != '0) ||
                      (req_word.operation == OP_LOOKUP && req_word.target_ip != '0);

   assign rd_en    = (state_ff == S_SCAN) && (cnt_ff < CNT_END);
   assign rd_addr  = cnt_ff[IDX_W-1:0];
   assign rd_entry = entry_type'(rd_bits);
   assign match    = pend_ff && valid_ff[idx_ff] && (rd_entry.ip == key_ff);

   assign arp_store = (req_ff.operation == OP_ARP_FRAME) &&
                      (req_ff.arp_opcode == ARP_REQUEST || req_ff.arp_opcode == ARP_REPLY);
   assign do_insert = (arp_store ||
                       (req_ff.operation == OP_LEARN && !hit_ff)) &&
                      (req_ff.sender_ip != '0);

   assign wr_en         = (state_ff == S_FINISH) && do_insert && free_found;
   assign wr_entry.ip   = req_ff.sender_ip;
   assign wr_entry.mac  = req_ff.sender_mac;
   assign wr_entry.port = req_ff.port;

   // response word for the event held in req_ff
   always_comb begin
      rsp_in = '0;
      case (req_ff.operation)
         OP_ARP_FRAME: begin
            if (!arp_store) begin
               rsp_in.status = ST_BAD_CODE;
            end else begin
               if (req_ff.sender_ip == '0) begin
                  rsp_in.status = ST_ZERO_IP;
               end else if (!free_found) begin
                  rsp_in.status = ST_FULL;
               end
               if (req_ff.arp_opcode == ARP_REQUEST && req_ff.target_ip == local_ip_ff) begin
                  rsp_in.send_reply = 1'b1;
                  rsp_in.reply_ip   = req_ff.sender_ip;
                  rsp_in.result_mac = req_ff.sender_mac;
               end
            end
         end
         OP_LEARN: begin
            if (req_ff.sender_ip == '0) begin
               rsp_in.status = ST_ZERO_IP;
            end else if (hit_ff) begin
               rsp_in.hit         = 1'b1;
               rsp_in.result_mac  = hit_mac_ff;
               rsp_in.result_port = hit_port_ff;
            end else if (!free_found) begin
               rsp_in.status = ST_FULL;
            end
         end
         OP_LOOKUP: begin
            if (req_ff.target_ip == '0) begin
               rsp_in.status = ST_ZERO_IP;
            end else if (hit_ff) begin
               rsp_in.hit         = 1'b1;
               rsp_in.result_mac  = hit_mac_ff;
               rsp_in.result_port = hit_port_ff;
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         local_ip_ff   <= '0;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         pend_ff       <= 1'b0;
         hit_ff        <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         rsp_strobe_ff <= (state_ff == S_FINISH);
         if (csr_wr_en) begin
            local_ip_ff <= csr_wr_data;
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff  <= req_word;
                  key_ff  <= (req_word.operation == OP_LEARN) ? req_word.sender_ip
                                                               : req_word.target_ip;
                  cnt_ff  <= '0;
                  pend_ff <= 1'b0;
                  hit_ff  <= 1'b0;
                  state_ff <= need_scan ? S_SCAN : S_FINISH;
               end
            end
            S_SCAN: begin
               pend_ff <= rd_en;
               idx_ff  <= rd_addr;
               if (rd_en) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
               if (match) begin
                  hit_ff      <= 1'b1;
                  hit_mac_ff  <= rd_entry.mac;
                  hit_port_ff <= rd_entry.port;
                  state_ff    <= S_FINISH;
               end else if (pend_ff && idx_ff == LAST_IDX) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (wr_en) begin
                  valid_ff[free_idx] <= 1'b1;
               end
               rsp_word_ff   <= rsp_in;
               state_ff      <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   arpc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (free_idx),
      .wr_data (ENTRY_W'(wr_entry)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two response words back to back");

   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.hit) |-> (rsp_word.status == ST_OK && !rsp_word.send_reply))
      else $error("hit with error status or reply");

endmodule
